// ----- design/ppgsp_pkg.sv -----
// ppgsp_pkg: shared types and constants for the ppg slope pulse rate detector
// used by ppgsp_ctrl, ppgsp_dp and the top level; no dependencies
package ppgsp_pkg;

	localparam int STEP_W     = 8;
	localparam int RATE_W     = 17;
	localparam int SCALE_W    = 7;
	localparam int SRATE_W    = 10;
	localparam int THR_W      = 18;
	localparam int FALL_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;
	localparam int DIV_STEPS  = RATE_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [SRATE_W-1:0] SRATE_RESET  = SRATE_W'(25);
	localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(60);
	localparam logic [THR_W-1:0]   THR_RESET    = THR_W'(1600);
	localparam logic [FALL_W-1:0]  FALL_RESET   = FALL_W'(7);
	localparam logic [FALL_W-1:0]  FALL_MAX     = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_RATE       = 2'd0,
		REG_RATE_SCALE        = 2'd1,
		REG_SLOPE_THRESHOLD   = 2'd2,
		REG_FALL_COUNT_NEEDED = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_needed;
	} sts_t;

endpackage

// ----- design/ppgsp_ctrl.sv -----
// ppgsp_ctrl: controller state machine for the pulse rate detector
// sequences request intake, the bit-serial divide and the output register; uses ppgsp_pkg
module ppgsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ppgsp_pkg::sts_t   sts,
	output ppgsp_pkg::cmd_t   cmd
);
	import ppgsp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.div_needed ? ST_DIV : ST_WAIT;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
					state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- design/ppgsp_dp.sv -----
// ppgsp_dp: datapath of the pulse rate detector
// config registers, slope and peak tracking state, restoring divider, output register; uses ppgsp_pkg
module ppgsp_dp #(
	parameter int SAMPLE_BITS = 18
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [SAMPLE_BITS-1:0]           sample,
	input  logic                             cfg_we,
	input  logic [ppgsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppgsp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  ppgsp_pkg::cmd_t                  cmd,
	output ppgsp_pkg::sts_t                  sts,
	output logic [ppgsp_pkg::RATE_W-1:0]     pulse_rate,
	output logic                             beat_confirmed
);
	import ppgsp_pkg::*;

	localparam int SLOPE_W = SAMPLE_BITS + 1;
	localparam int CMP_W   = SAMPLE_BITS + THR_W + 1;

	logic [SRATE_W-1:0]        srate_q;
	logic [SCALE_W-1:0]        scale_q;
	logic [THR_W-1:0]          thr_q;
	logic [FALL_W-1:0]         fall_need_q;

	logic [SAMPLE_BITS-1:0]    prev_q;
	logic signed [SLOPE_W-1:0] last_q, before_q;
	logic [STEP_W-1:0]         step_q, cand_q, beat_pos_q;
	logic                      falling_q, armed_q;
	logic [FALL_W-1:0]         fc_q;

	logic [RATE_W-1:0]         quot_q;
	logic [STEP_W-1:0]         rem_q, divisor_q;
	logic                      conf_q;
	logic [RATE_W-1:0]         rate_out_q;
	logic                      conf_out_q;

	logic signed [SLOPE_W-1:0] slope;
	logic [SLOPE_W-1:0]        mag_last, mag_before;
	logic                      slope_neg, slope_pos, cand_start, confirm, report;
	logic [FALL_W-1:0]         needed, fc1, fc2;
	logic                      fall1, fall2;
	logic [STEP_W-1:0]         step_d, cand1, interval;
	logic [RATE_W-1:0]         dividend;
	logic [STEP_W:0]           rem_sh;
	logic                      q_bit;

	always_comb begin
		slope      = $signed({1'b0, sample}) - $signed({1'b0, prev_q});
		slope_neg  = slope[SLOPE_W-1];
		slope_pos  = !slope_neg && (slope != '0);
		mag_last   = last_q[SLOPE_W-1] ? SLOPE_W'(-last_q) : SLOPE_W'(last_q);
		mag_before = before_q[SLOPE_W-1] ? SLOPE_W'(-before_q) : SLOPE_W'(before_q);
		needed     = (fall_need_q == '0) ? FALL_W'(1) : fall_need_q;
		step_d     = step_q + STEP_W'(1);
		cand_start = slope_neg && !last_q[SLOPE_W-1] && !falling_q &&
			((CMP_W'(mag_last) > CMP_W'(thr_q)) || (CMP_W'(mag_before) > CMP_W'(thr_q)));
		fall1 = falling_q || cand_start;
		fc1   = cand_start ? '0 : fc_q;
		cand1 = cand_start ? step_d : cand_q;
		fc2   = fc1;
		fall2 = fall1;
		if (fall1 && slope_neg) begin
			if (fc1 != FALL_MAX)
				fc2 = fc1 + FALL_W'(1);
		end else if (fall1 && slope_pos) begin
			fc2   = '0;
			fall2 = 1'b0;
		end
		confirm  = (fc2 >= needed);
		report   = confirm && armed_q;
		interval = cand1 - beat_pos_q;
		sts.div_needed = report && (interval != '0);
		dividend = RATE_W'({{(RATE_W-SCALE_W){1'b0}}, scale_q} *
			{{(RATE_W-SRATE_W){1'b0}}, srate_q});
		rem_sh = {rem_q, quot_q[RATE_W-1]};
		q_bit  = (rem_sh >= {1'b0, divisor_q});
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srate_q     <= SRATE_RESET;
			scale_q     <= SCALE_RESET;
			thr_q       <= THR_RESET;
			fall_need_q <= FALL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_RATE:       srate_q     <= cfg_data[SRATE_W-1:0];
				REG_RATE_SCALE:        scale_q     <= cfg_data[SCALE_W-1:0];
				REG_SLOPE_THRESHOLD:   thr_q       <= cfg_data[THR_W-1:0];
				REG_FALL_COUNT_NEEDED: fall_need_q <= cfg_data[FALL_W-1:0];
				default: ;
			endcase
		end
	end

	// peak tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			last_q     <= '0;
			before_q   <= '0;
			step_q     <= '0;
			cand_q     <= '0;
			beat_pos_q <= '0;
			falling_q  <= 1'b0;
			fc_q       <= '0;
			armed_q    <= 1'b0;
		end else if (cmd.load) begin
			prev_q   <= sample;
			last_q   <= slope;
			before_q <= last_q;
			step_q   <= step_d;
			cand_q   <= cand1;
			if (confirm) begin
				beat_pos_q <= cand1;
				armed_q    <= 1'b1;
				falling_q  <= 1'b0;
				fc_q       <= '0;
			end else begin
				falling_q <= fall2;
				fc_q      <= fc2;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q    <= sts.div_needed ? dividend : '0;
			rem_q     <= '0;
			divisor_q <= interval;
			conf_q    <= report;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[RATE_W-2:0], q_bit};
			rem_q  <= q_bit ? STEP_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[STEP_W-1:0];
		end
		if (cmd.out_load) begin
			rate_out_q <= quot_q;
			conf_out_q <= conf_q;
		end
	end

	assign pulse_rate     = rate_out_q;
	assign beat_confirmed = conf_out_q;

endmodule

// ----- design/ppg_slope_pulse_rate_detector.sv -----
// ppg_slope_pulse_rate_detector: top level, slope based pulse rate detector
// a request is loaded on acceptance and runs the 17-step bit-serial divider only when a
// beat rate is computed; in_stall holds new requests until the output register is loaded
// reset: asynchronous arst_n clears tracking state and loads register defaults
// (sample_rate 25, rate_scale 60, slope_threshold 1600, fall_count_needed 7)
module ppg_slope_pulse_rate_detector #(
	parameter int SAMPLE_BITS = 18
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [SAMPLE_BITS-1:0]           sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ppgsp_pkg::RATE_W-1:0]     pulse_rate,
	output logic                             beat_confirmed,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ppgsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppgsp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ppgsp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ppgsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppgsp_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.pulse_rate     (pulse_rate),
		.beat_confirmed (beat_confirmed)
	);

endmodule

// ----- sim/tb_ppg_slope_pulse_rate_detector.sv -----
// tb_ppg_slope_pulse_rate_detector: self-checking bench for the ppg slope pulse rate detector
// drives synthetic pulse trains and noise under random idling and compares every result
// against a cycle-free predictor; depends on ppgsp_pkg and ppg_slope_pulse_rate_detector
module tb_ppg_slope_pulse_rate_detector;
	import ppgsp_pkg::*;

	localparam int SAMPLE_W    = 18;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 8;
	localparam int WRAP_PHASE  = 6;
	localparam int PHASE_ITEMS = 80;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              beat;
	} beat_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [RATE_W-1:0]     pulse_rate;
	logic                  beat_confirmed;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SAMPLE_RATE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ppg_slope_pulse_rate_detector #(
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_rate(pulse_rate),
		.beat_confirmed(beat_confirmed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of registers and tracking state
	logic [SRATE_W-1:0]          fs_reg = SRATE_RESET;
	logic [SCALE_W-1:0]          scale_reg = SCALE_RESET;
	logic [THR_W-1:0]            thr_reg = THR_RESET;
	logic [FALL_W-1:0]           need_reg = FALL_RESET;
	logic [SAMPLE_W-1:0]         prev_level = '0;
	logic signed [SAMPLE_W:0]    slope_last = '0;
	logic signed [SAMPLE_W:0]    slope_prior = '0;
	logic [STEP_W-1:0]           step_cnt = '0;
	logic [STEP_W-1:0]           peak_pos = '0;
	logic [STEP_W-1:0]           beat_pos = '0;
	logic                        descending = 1'b0;
	logic                        armed = 1'b0;
	logic [FALL_W-1:0]           fall_run = '0;

	logic [SAMPLE_W-1:0] sample_pending_q[$];
	beat_result_t        rate_expected_q[$];

	bit idle_on = 1'b1;
	bit in_taken = 1'b0;
	int in_gap = 0;
	int out_gap = 0;
	int errors = 0;
	int cycles = 0;
	int queued = 0;
	int wave_level = 0;

	function automatic logic [SAMPLE_W:0] slope_size(input logic signed [SAMPLE_W:0] s);
		return (s < 0) ? -s : s;
	endfunction

	function automatic beat_result_t track_sample(input logic [SAMPLE_W-1:0] value);
		logic signed [SAMPLE_W:0] slope;
		logic [FALL_W-1:0]        needed;
		logic [STEP_W-1:0]        interval;
		beat_result_t             res;
		slope = $signed({1'b0, value}) - $signed({1'b0, prev_level});
		needed = (need_reg == '0) ? FALL_W'(1) : need_reg;
		res = '0;
		step_cnt = step_cnt + 1'b1;
		if (slope < 0 && slope_last >= 0 && !descending &&
				(slope_size(slope_last) > thr_reg || slope_size(slope_prior) > thr_reg)) begin
			peak_pos = step_cnt;
			descending = 1'b1;
			fall_run = '0;
		end
		if (descending && slope < 0) begin
			if (fall_run != FALL_MAX)
				fall_run = fall_run + 1'b1;
		end else if (descending && slope > 0) begin
			fall_run = '0;
			descending = 1'b0;
		end
		if (fall_run >= needed) begin
			if (armed) begin
				interval = peak_pos - beat_pos;
				if (interval != '0)
					res.rate = RATE_W'((32'(scale_reg) * 32'(fs_reg)) / 32'(interval));
				res.beat = 1'b1;
			end
			beat_pos = peak_pos;
			armed = 1'b1;
			descending = 1'b0;
			fall_run = '0;
		end
		slope_prior = slope_last;
		slope_last = slope;
		prev_level = value;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		errors++;
		$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
	endtask

	task automatic queue_level(input int lvl);
		wave_level = (lvl < 0) ? 0 : (lvl > SAMPLE_MAX) ? SAMPLE_MAX : lvl;
		sample_pending_q.push_back(SAMPLE_W'(wave_level));
		queued++;
	endtask

	// rise, fall and baseline per beat; a nonzero period keeps the beats exactly that far apart
	task automatic add_train(input int beats, input int fixed_period);
		int step, rise_n, fall_n, need, start, base, d, period;
		bit broken;
		need = (need_reg == '0) ? 1 : int'(need_reg);
		step = int'(thr_reg) + 1 + int'($urandom_range(0, 3000));
		if (step > SAMPLE_MAX)
			step = SAMPLE_MAX;
		if (wave_level + step > SAMPLE_MAX)
			queue_level(int'($urandom_range(0, 2000)));
		rise_n = $urandom_range(1, 5);
		if (rise_n * step > SAMPLE_MAX - wave_level)
			rise_n = (SAMPLE_MAX - wave_level) / step;
		if (rise_n == 0)
			rise_n = 1;
		for (int b = 0; b < beats; b++) begin
			start = queued;
			base = wave_level;
			period = (fixed_period != 0) ? fixed_period :
				rise_n + need + int'($urandom_range(4, 60));
			for (int i = 0; i < rise_n; i++)
				queue_level(wave_level + step);
			broken = (fixed_period == 0) && ($urandom_range(0, 5) == 0);
			fall_n = broken ? int'($urandom_range(0, need - 1)) :
				need + int'($urandom_range(0, 3));
			for (int i = 0; i < fall_n; i++) begin
				if (i > 0 && $urandom_range(0, 7) == 0)
					queue_level(wave_level);
				d = (wave_level - base) / (fall_n - i);
				queue_level(wave_level - ((d < 1) ? 1 : d));
			end
			if (broken)
				queue_level(wave_level + 1 + int'($urandom_range(0, 50)));
			if (fixed_period != 0) begin
				queue_level(wave_level);
				queue_level(wave_level);
			end
			while (queued - start < period)
				queue_level(wave_level + int'($urandom_range(0, 40)) - 20);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_SAMPLE_RATE:       fs_reg = SRATE_W'(value);
			REG_RATE_SCALE:        scale_reg = SCALE_W'(value);
			REG_SLOPE_THRESHOLD:   thr_reg = THR_W'(value);
			REG_FALL_COUNT_NEEDED: need_reg = FALL_W'(value);
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (sample_pending_q.size() != 0 || rate_expected_q.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// sample requests: predict at acceptance
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			rate_expected_q.push_back(track_sample(sample));
			void'(sample_pending_q.pop_front());
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (in_gap == 0 && idle_on && $urandom_range(0, 5) == 0)
				in_gap = $urandom_range(1, 19);
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (sample_pending_q.size() > 0) begin
				in_valid <= 1'b1;
				sample <= sample_pending_q[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_gap == 0 && idle_on && $urandom_range(0, 5) == 0)
			out_gap = $urandom_range(1, 19);
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		beat_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rate_expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, pulse_rate %0d beat_confirmed %0d",
					$time, pulse_rate, beat_confirmed);
			end else begin
				want = rate_expected_q.pop_front();
				if (pulse_rate !== want.rate)
					report_mismatch("pulse_rate", want.rate, pulse_rate);
				if (beat_confirmed !== want.beat)
					report_mismatch("beat_confirmed", want.beat, beat_confirmed);
			end
		end
	end

	initial begin
		int seq_a[11] = '{0, 262143, 262143, 262142, 262142, 262141, 262140, 262139,
			262138, 262137, 262136};
		int seq_b[7] = '{0, 5, 0, 262143, 0, 1, 0};
		int srate, scale, thr, need;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default registers: steep edge, fall with a flat step, first peak only arms
		foreach (seq_a[i])
			queue_level(seq_a[i]);
		wait_drain();

		// zero threshold, zero fall count, rate product 1000 * 120 within range
		write_reg(REG_SAMPLE_RATE, 1000);
		write_reg(REG_RATE_SCALE, 120);
		write_reg(REG_SLOPE_THRESHOLD, 0);
		write_reg(REG_FALL_COUNT_NEEDED, 0);
		foreach (seq_b[i])
			queue_level(seq_b[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drain();
			case (ph)
				0: begin
					srate = 1;
					scale = 1;
					thr = 0;
					need = 15;
				end
				1: begin
					srate = 1023;
					scale = 127;
					thr = SAMPLE_MAX;
					need = 0;
				end
				WRAP_PHASE: begin
					srate = $urandom_range(1, 1000);
					scale = $urandom_range(1, 120);
					thr = $urandom_range(50, 5000);
					need = $urandom_range(3, 15);
				end
				default: begin
					srate = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) :
						$urandom_range(1, 1000);
					scale = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) :
						$urandom_range(1, 120);
					thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SAMPLE_MAX) :
						$urandom_range(0, 20000);
					need = $urandom_range(0, 15);
				end
			endcase
			write_reg(REG_SAMPLE_RATE, srate);
			write_reg(REG_RATE_SCALE, scale);
			write_reg(REG_SLOPE_THRESHOLD, thr);
			write_reg(REG_FALL_COUNT_NEEDED, need);
			idle_on = (ph != 4) && (ph < PHASES - 2);
			queued = 0;
			// beats a full step-counter wrap apart
			if (ph == WRAP_PHASE)
				add_train(2, 256);
			while (queued < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 7)
					add_train($urandom_range(1, 4), 0);
				else
					repeat ($urandom_range(2, 12))
						queue_level(int'($urandom_range(0, SAMPLE_MAX)));
			end
		end

		wait_drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ppgsp_pkg.sv
design/ppgsp_ctrl.sv
design/ppgsp_dp.sv
design/ppg_slope_pulse_rate_detector.sv
sim/tb_ppg_slope_pulse_rate_detector.sv
